[hw/rtl/ttli_pkg.sv]
// Shared constants, types and state codes of the time-table linear interpolator.
`default_nettype none
package ttli_pkg;
	localparam int NUM_SPECIES = 2;
	localparam int NUM_FACES   = 6;
	localparam int ROWS        = 256;
	localparam int MAX_VALUES  = 8;
	localparam int ROW_WORDS   = MAX_VALUES + 1;
	localparam int NUM_TABLES  = NUM_SPECIES * NUM_FACES;
	localparam int STORE_DEPTH = NUM_TABLES * ROWS * ROW_WORDS;
	localparam int TBL_W       = $clog2(NUM_TABLES);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int CNT_W       = $clog2(ROWS + 1);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int RESULT_CAP  = 8;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		logic              is_query;
		logic [TBL_W-1:0]  tbl;
		logic [ROW_W-1:0]  row;
		logic [3:0]        col;
		logic [31:0]       data;
		logic [CNT_W-1:0]  n;
		logic [3:0]        cnt;
	} q_item_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SCAN_RD,
		B_SCAN_CMP,
		B_DIV,
		B_RD_A,
		B_RD_B,
		B_MUL,
		B_OUT,
		B_EMPTY
	} back_state_t;
endpackage
`default_nettype wire

[hw/rtl/time_table_linear_interpolator_core.sv]
// Top level of the time-table linear interpolator.
// Usage: a beat is taken when start is high and busy is low. mode selects a
// table write (row, column, entry_value), a query (query_time) or a clear.
// cfg_we with cfg_wdata sets value_count (reset 8); the user is to write it
// only while the block is idle, which the block itself does not enforce.
// Each query gives value_count results (0 counts as 1, above 8 as 8), one
// per cycle in which result_valid is high, with value_index counting up and
// last on the final one; an empty table gives zeros with table_empty set.
// The receiver cannot stall. A query searches the rows in turn (one read
// port of the table memory, one compare), runs the fraction divider when it
// lands between two rows, and for each emitted value does two reads, one
// multiply and one add.
// A two-beat queue between the front and the back lets new beats be taken
// while a query is being worked; busy rises when that queue is full.
// Reset clears the row counts, so all tables read as empty; memory contents
// are not cleared and must be written before a query uses them.
`default_nettype none
module time_table_linear_interpolator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic        species,
	input  wire logic [2:0]  face,
	input  wire logic [7:0]  row,
	input  wire logic [3:0]  column,
	input  wire logic [31:0] entry_value,
	input  wire logic [31:0] query_time,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	output logic             result_valid,
	output logic [31:0]      value,
	output logic [2:0]       value_index,
	output logic             last,
	output logic             table_empty
);
	logic [3:0] value_count_q;
	logic       push, pop, q_full, q_empty;
	ttli_pkg::q_item_t push_item, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_count_q <= 4'd8;
		end else if (cfg_we) begin
			value_count_q <= cfg_wdata;
		end
	end

	assign busy = q_full;

	ttli_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(start && !busy),
		.mode(mode), .species(species), .face(face), .row(row), .column(column),
		.entry_value(entry_value), .query_time(query_time),
		.value_count(value_count_q), .push(push), .push_item(push_item)
	);

	ttli_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .head(head), .full(q_full), .empty(q_empty)
	);

	ttli_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .head(head), .pop(pop),
		.result_valid(result_valid), .value(value), .value_index(value_index),
		.last(last), .table_empty(table_empty)
	);
endmodule
`default_nettype wire

[hw/rtl/ttli_queue.sv]
// Two-entry queue that carries classified beats from the front to the back.
`default_nettype none
module ttli_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ttli_pkg::q_item_t push_item,
	input  wire logic              pop,
	output ttli_pkg::q_item_t      head,
	output logic                   full,
	output logic                   empty
);
	ttli_pkg::q_item_t slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head  = slot_q[rd_q];
	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
endmodule
`default_nettype wire

[hw/rtl/ttli_front.sv]
// Front end: accepts beats, keeps the row counts and queues writes and queries.
`default_nettype none
module ttli_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire logic [1:0]   mode,
	input  wire logic         species,
	input  wire logic [2:0]   face,
	input  wire logic [7:0]   row,
	input  wire logic [3:0]   column,
	input  wire logic [31:0]  entry_value,
	input  wire logic [31:0]  query_time,
	input  wire logic [3:0]   value_count,
	output logic              push,
	output ttli_pkg::q_item_t push_item
);
	logic [ttli_pkg::CNT_W-1:0] row_count_q [ttli_pkg::NUM_TABLES];
	logic                       addr_ok;
	logic [ttli_pkg::TBL_W-1:0] tbl;
	logic [ttli_pkg::CNT_W-1:0] row_plus;
	logic                       wr_ok;
	logic [3:0]                 cnt;

	always_comb begin
		addr_ok  = ({3'd0, species} < 4'(ttli_pkg::NUM_SPECIES)) &&
			({1'b0, face} < 4'(ttli_pkg::NUM_FACES));
		tbl      = addr_ok ? ttli_pkg::TBL_W'({3'd0, species} * 4'(ttli_pkg::NUM_FACES)
			+ {1'b0, face}) : '0;
		row_plus = ttli_pkg::CNT_W'(row) + ttli_pkg::CNT_W'(1);
		wr_ok    = addr_ok && (column <= 4'(ttli_pkg::MAX_VALUES));
		if (value_count == 4'd0) begin
			cnt = 4'd1;
		end else if (value_count > 4'(ttli_pkg::MAX_VALUES)) begin
			cnt = 4'(ttli_pkg::MAX_VALUES);
		end else begin
			cnt = value_count;
		end
		if (cnt > 4'(ttli_pkg::RESULT_CAP)) begin
			cnt = 4'(ttli_pkg::RESULT_CAP);
		end
	end

	always_comb begin
		push = 1'b0;
		push_item.is_query = (mode == ttli_pkg::MODE_QUERY);
		push_item.tbl      = tbl;
		push_item.row      = row;
		push_item.col      = column;
		push_item.data     = (mode == ttli_pkg::MODE_QUERY) ? query_time : entry_value;
		push_item.n        = addr_ok ? row_count_q[tbl] : '0;
		push_item.cnt      = cnt;
		if (accept) begin
			case (mode)
				ttli_pkg::MODE_WRITE: begin
					push = wr_ok;
				end
				ttli_pkg::MODE_QUERY: begin
					push = 1'b1;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ttli_pkg::NUM_TABLES; i++) begin
				row_count_q[i] <= '0;
			end
		end else if (accept) begin
			if (mode == ttli_pkg::MODE_WRITE && wr_ok && row_count_q[tbl] < row_plus) begin
				row_count_q[tbl] <= row_plus;
			end else if (mode == ttli_pkg::MODE_CLEAR && addr_ok) begin
				row_count_q[tbl] <= '0;
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/ttli_back.sv]
// Back end: table memory, row search, fraction divider and blend of each value.
`default_nettype none
module ttli_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire ttli_pkg::q_item_t head,
	output logic                   pop,
	output logic                   result_valid,
	output logic [31:0]            value,
	output logic [2:0]             value_index,
	output logic                   last,
	output logic                   table_empty
);
	ttli_pkg::back_state_t state_q, state_d;
	logic [31:0] mem [ttli_pkg::STORE_DEPTH];
	logic [31:0] rd_q;
	logic [ttli_pkg::ADDR_W-1:0] addr;
	logic        we;

	ttli_pkg::q_item_t item_q;
	logic [ttli_pkg::ROW_W-1:0] i_q, lo_q, hi_q;
	logic [31:0] prev_q, a_q;
	logic [33:0] rem_q, den_q;
	logic [33:0] rem_nx;
	logic [16:0] s_q;
	logic [4:0]  div_cnt_q;
	logic [3:0]  k_q;
	logic [50:0] prod_q;
	logic        hit, at_end, last_k, trial;
	logic [ttli_pkg::ROW_W-1:0] rd_row;
	logic [3:0]  rd_col;

	function automatic logic [ttli_pkg::ADDR_W-1:0] word_addr(
		input logic [ttli_pkg::TBL_W-1:0] tbl,
		input logic [ttli_pkg::ROW_W-1:0] r,
		input logic [3:0] c
	);
		logic [ttli_pkg::ADDR_W-1:0] base;
		base = ttli_pkg::ADDR_W'({tbl, r}) * ttli_pkg::ADDR_W'(ttli_pkg::ROW_WORDS);
		return base + ttli_pkg::ADDR_W'(c);
	endfunction

	always_comb begin
		hit    = ($signed(rd_q) >= $signed(item_q.data));
		at_end = (ttli_pkg::CNT_W'(i_q) == item_q.n - ttli_pkg::CNT_W'(1));
		last_k = (k_q + 4'd1 == item_q.cnt);
		trial  = (rem_q >= den_q);
		rem_nx = trial ? rem_q - den_q : rem_q;
		pop    = (state_q == ttli_pkg::B_IDLE) && !q_empty;
		we     = pop && !head.is_query;
		rd_row = i_q;
		rd_col = 4'd0;
		case (state_q)
			ttli_pkg::B_RD_A: begin
				rd_row = lo_q;
				rd_col = k_q + 4'd1;
			end
			ttli_pkg::B_RD_B: begin
				rd_row = hi_q;
				rd_col = k_q + 4'd1;
			end
			default: begin
				rd_row = i_q;
				rd_col = 4'd0;
			end
		endcase
		addr = we ? word_addr(head.tbl, head.row, head.col)
			: word_addr(item_q.tbl, rd_row, rd_col);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= head.data;
		end
		rd_q <= mem[addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ttli_pkg::B_IDLE: begin
				if (pop && head.is_query) begin
					state_d = (head.n == '0) ? ttli_pkg::B_EMPTY : ttli_pkg::B_SCAN_RD;
				end
			end
			ttli_pkg::B_SCAN_RD: begin
				state_d = ttli_pkg::B_SCAN_CMP;
			end
			ttli_pkg::B_SCAN_CMP: begin
				if (hit && i_q != '0) begin
					state_d = ttli_pkg::B_DIV;
				end else if (hit || at_end) begin
					state_d = ttli_pkg::B_RD_A;
				end else begin
					state_d = ttli_pkg::B_SCAN_RD;
				end
			end
			ttli_pkg::B_DIV: begin
				if (div_cnt_q == 5'd16) begin
					state_d = ttli_pkg::B_RD_A;
				end
			end
			ttli_pkg::B_RD_A: begin
				state_d = ttli_pkg::B_RD_B;
			end
			ttli_pkg::B_RD_B: begin
				state_d = ttli_pkg::B_MUL;
			end
			ttli_pkg::B_MUL: begin
				state_d = ttli_pkg::B_OUT;
			end
			ttli_pkg::B_OUT: begin
				state_d = last_k ? ttli_pkg::B_IDLE : ttli_pkg::B_RD_A;
			end
			ttli_pkg::B_EMPTY: begin
				if (last_k) begin
					state_d = ttli_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = ttli_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ttli_pkg::B_IDLE;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= (state_q == ttli_pkg::B_OUT) || (state_q == ttli_pkg::B_EMPTY);
		end
	end

	// Datapath registers; the divider produces one fraction bit per cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			ttli_pkg::B_IDLE: begin
				item_q <= head;
				i_q    <= '0;
				k_q    <= 4'd0;
				s_q    <= '0;
			end
			ttli_pkg::B_SCAN_CMP: begin
				if (hit) begin
					lo_q  <= (i_q == '0) ? i_q : i_q - ttli_pkg::ROW_W'(1);
					hi_q  <= i_q;
					rem_q <= 34'($signed({item_q.data[31], item_q.data})
						- $signed({prev_q[31], prev_q}));
					den_q <= 34'($signed({rd_q[31], rd_q}) - $signed({prev_q[31], prev_q}));
					div_cnt_q <= 5'd0;
				end else if (at_end) begin
					lo_q <= i_q;
					hi_q <= i_q;
				end else begin
					prev_q <= rd_q;
					i_q    <= i_q + ttli_pkg::ROW_W'(1);
				end
			end
			ttli_pkg::B_DIV: begin
				s_q       <= {s_q[15:0], trial};
				rem_q     <= {rem_nx[32:0], 1'b0};
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			ttli_pkg::B_RD_B: begin
				a_q <= rd_q;
			end
			ttli_pkg::B_MUL: begin
				prod_q <= 51'($signed({1'b0, s_q}) * $signed({rd_q[31], rd_q} - {a_q[31], a_q}));
			end
			ttli_pkg::B_OUT: begin
				value       <= a_q + prod_q[47:16];
				value_index <= k_q[2:0];
				last        <= last_k;
				table_empty <= 1'b0;
				k_q         <= k_q + 4'd1;
			end
			ttli_pkg::B_EMPTY: begin
				value       <= '0;
				value_index <= k_q[2:0];
				last        <= last_k;
				table_empty <= 1'b1;
				k_q         <= k_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttli_pkg::B_RD_A) |-> (s_q <= 17'd65536))
		else $error("fraction above one");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && table_empty) |-> (value == 32'd0))
		else $error("empty table result not zero");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttli_pkg::B_OUT && !last_k) |=> (state_q == ttli_pkg::B_RD_A && !pop))
		else $error("queue popped during a query");
endmodule
`default_nettype wire
